// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sprite row decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is high
`define RSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define RSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types, register codes and color expansion for the sprite row decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int CsrWidthW = 2;
   localparam int CsrDataW  = 10;

   localparam logic [CsrWidthW-1:0] CsrSpriteWidth  = 2'd0;
   localparam logic [CsrWidthW-1:0] CsrSpriteHeight = 2'd1;
   localparam logic [CsrWidthW-1:0] CsrDecodeMode   = 2'd2;

   localparam logic [7:0]  CmdEndRow   = 8'h00;
   localparam logic [7:0]  MaskCount   = 8'h7F;
   localparam logic [7:0]  ScaleRg     = 8'd36;
   localparam logic [7:0]  ScaleBlue   = 8'd85;
   localparam logic [7:0]  MaskRed     = 8'hE0;
   localparam logic [7:0]  MaskGreen   = 8'h1C;
   localparam logic [31:0] AlphaOpaque = 32'hFF000000;
   localparam int          ColumnSat   = 4095;

   typedef struct packed {
      logic [9:0] width;
      logic [9:0] height;
      logic       raw_mode;
   } rsd_cfg_type;

   typedef struct packed {
      logic [8:0] row_number;
      logic       row_start;
      logic [7:0] data_byte;
   } rsd_item_type;

   typedef struct packed {
      logic [31:0] argb;
      logic [8:0]  row;
      logic [8:0]  column;
   } rsd_pixel_type;

   // 3-3-2 index scaled by 36/36/85, index 0 transparent
   function automatic logic [31:0] rle_colour(input logic [7:0] c);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = {5'd0, c[7:5]} * ScaleRg;
      g = {5'd0, c[4:2]} * ScaleRg;
      b = {6'd0, c[1:0]} * ScaleBlue;
      if (c == 8'd0) begin
         rle_colour = 32'd0;
      end else begin
         rle_colour = AlphaOpaque | {8'd0, r, g, b};
      end
   endfunction

   // 3-3-2 index placed in the top bits of each channel
   function automatic logic [31:0] raw_colour(input logic [7:0] c);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = c & MaskRed;
      g = (c & MaskGreen) << 3;
      b = {c[1:0], 6'd0};
      if (c == 8'd0) begin
         raw_colour = 32'd0;
      end else begin
         raw_colour = AlphaOpaque | {8'd0, r, g, b};
      end
   endfunction

endpackage

// File: rtl/rsd_csr.sv
// ----------------------------------------------------------------------------
// rsd_csr
// Configuration registers: sprite width, sprite height, decode mode.
// ----------------------------------------------------------------------------
module rsd_csr
   import rsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CsrWidthW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output rsd_cfg_type          cfg
);

   rsd_cfg_type cfg_ff;
   rsd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CsrSpriteWidth:  cfg_in.width    = csr_wdata;
            CsrSpriteHeight: cfg_in.height   = csr_wdata;
            CsrDecodeMode:   cfg_in.raw_mode = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width    <= 10'd1;
         cfg_ff.height   <= 10'd1;
         cfg_ff.raw_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/rsd_in_stage.sv
// ----------------------------------------------------------------------------
// rsd_in_stage
// Input register; holds one item until the decode stage takes it.
// ----------------------------------------------------------------------------
module rsd_in_stage
   import rsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsd_item_type in_item,
   input  logic         space,
   output logic         fire,
   output rsd_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   rsd_item_type item_ff;

   assign fire     = valid_ff && space;
   assign in_ready = !valid_ff || space;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item = item_ff;

endmodule

// File: rtl/rsd_decode.sv
// ----------------------------------------------------------------------------
// rsd_decode
// Row state and single-pass byte decode for run-length and raw sprites.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsd_decode
   import rsd_pkg::*;
#(
   parameter int MAX_DIM = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  rsd_cfg_type   cfg,
   input  logic          fire,
   input  rsd_item_type  item,
   output logic          emit,
   output rsd_pixel_type pixel
);

   localparam int ColW  = $clog2(MAX_DIM + 128);
   localparam int RowW  = $clog2(MAX_DIM + 1);
   localparam int CmpW  = (ColW + 1 > 13) ? ColW + 1 : 13;

   logic [ColW-1:0] col_ff, col_in, col_v;
   logic [RowW-1:0] row_ff, row_in, row_v;
   logic [6:0]      lit_ff, lit_in, lit_v;
   logic            closed_ff, closed_in, closed_v;

   logic [CmpW-1:0] w_eff, h_eff, rown_w, col_w, row_w, col_next, row_next, skip_sum;

   always_comb begin
      w_eff = (CmpW'(cfg.width) > CmpW'(MAX_DIM)) ? CmpW'(MAX_DIM) : CmpW'(cfg.width);
      h_eff = (CmpW'(cfg.height) > CmpW'(MAX_DIM)) ? CmpW'(MAX_DIM) : CmpW'(cfg.height);
      rown_w = CmpW'(item.row_number);

      col_v    = col_ff;
      row_v    = row_ff;
      lit_v    = lit_ff;
      closed_v = closed_ff;

      if (item.row_start) begin
         col_v = '0;
         lit_v = '0;
         if (cfg.raw_mode) begin
            row_v    = '0;
            closed_v = (w_eff == '0) || (h_eff == '0);
         end else begin
            row_v    = rown_w[RowW-1:0];
            closed_v = (w_eff == '0) || (rown_w >= h_eff);
         end
      end

      col_w        = CmpW'(col_v);
      row_w        = CmpW'(row_v);
      col_next     = col_w + CmpW'(1);
      row_next     = row_w + CmpW'(1);
      skip_sum     = col_w + CmpW'(item.data_byte & MaskCount);
      pixel.column = col_w[8:0];
      pixel.row    = row_w[8:0];
      pixel.argb   = cfg.raw_mode ? raw_colour(item.data_byte) : rle_colour(item.data_byte);
      emit         = 1'b0;

      if (!closed_v) begin
         if (cfg.raw_mode) begin
            emit = 1'b1;
            if (col_next >= w_eff) begin
               col_v = '0;
               row_v = row_next[RowW-1:0];
               if (row_next >= h_eff) begin
                  closed_v = 1'b1;
               end
            end else begin
               col_v = col_next[ColW-1:0];
            end
         end else if (lit_v != '0) begin
            emit  = 1'b1;
            lit_v = lit_v - 7'd1;
            col_v = col_next[ColW-1:0];
            if (col_next >= w_eff) begin
               closed_v = 1'b1;
               lit_v    = '0;
            end
         end else if (item.data_byte == CmdEndRow) begin
            closed_v = 1'b1;
         end else if (item.data_byte[7]) begin
            // skip saturates at the column limit
            if (skip_sum > CmpW'(ColumnSat)) begin
               skip_sum = CmpW'(ColumnSat);
            end
            col_v = skip_sum[ColW-1:0];
            if (skip_sum >= w_eff) begin
               closed_v = 1'b1;
            end
         end else begin
            lit_v = item.data_byte[6:0];
         end
      end

      emit      = emit && fire;
      col_in    = fire ? col_v    : col_ff;
      row_in    = fire ? row_v    : row_ff;
      lit_in    = fire ? lit_v    : lit_ff;
      closed_in = fire ? closed_v : closed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         lit_ff    <= '0;
         closed_ff <= 1'b1;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         lit_ff    <= lit_in;
         closed_ff <= closed_in;
      end
   end

   `RSD_ASSERT(a_emit_needs_fire, clock, reset, emit |-> fire, "pixel without an item")
   `RSD_ASSERT(a_closed_ignores, clock, reset,
      (fire && closed_ff && !item.row_start) |-> !emit, "pixel from a closed row")
   `RSD_ASSERT(a_idle_holds, clock, reset,
      !fire |=> ($stable(col_ff) && $stable(lit_ff) && $stable(closed_ff)),
      "row state moved without an item")
   `RSD_ASSERT(a_literal_count, clock, reset,
      (fire && !cfg.raw_mode && !closed_ff && !item.row_start && lit_ff != '0)
      |=> (closed_ff || lit_ff == $past(lit_ff) - 7'd1), "literal count slip")

endmodule

// File: rtl/rsd_out_stage.sv
// ----------------------------------------------------------------------------
// rsd_out_stage
// Result register toward the pixel channel.
// ----------------------------------------------------------------------------
module rsd_out_stage
   import rsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsd_pixel_type pixel,
   output logic          space,
   output logic          out_valid,
   input  logic          out_ready,
   output rsd_pixel_type out_pixel
);

   logic          valid_ff;
   logic          valid_in;
   rsd_pixel_type pixel_ff;

   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

// File: rtl/rle_sprite_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder_unit
// Sprite byte stream to pixel writes, run-length rows or raw raster bytes.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_*     in         one sprite byte with row start flag and row number
//  rsp_*     out        one pixel write: column, row, ARGB
//  csr_*     in         register writes: width, height, mode
//
//  One item per cycle sustained while the result is not stalled; a byte goes
//  input register -> decode -> result register, and the decode is combinational.
//  The row counters update in the same cycle as the decode, which sets the rate.
//  Reset is synchronous and closes the row until the next row start.
//  A stalled result holds the pipe; req_tready drops only when both
//  registers are full and rsp_tready is low.
// ----------------------------------------------------------------------------
module rle_sprite_row_decoder_unit
   import rsd_pkg::*;
#(
   parameter int MAX_DIM = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // data_byte[7:0], row_number[16:8]
   input  logic                 req_tuser,   // row_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,   // column[8:0], row[17:9], argb[49:18]
   input  logic                 csr_wen,
   input  logic [CsrWidthW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   rsd_cfg_type   cfg;
   rsd_item_type  in_item;
   rsd_item_type  item;
   rsd_pixel_type pixel;
   rsd_pixel_type out_pixel;
   logic          space;
   logic          fire;
   logic          emit;

   assign in_item.data_byte  = req_tdata[7:0];
   assign in_item.row_number = req_tdata[16:8];
   assign in_item.row_start  = req_tuser;

   rsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsd_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .space    (space),
      .fire     (fire),
      .item     (item)
   );

   rsd_decode #(
      .MAX_DIM (MAX_DIM)
   ) u_decode (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .item  (item),
      .emit  (emit),
      .pixel (pixel)
   );

   rsd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .pixel     (pixel),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (out_pixel)
   );

   assign rsp_tdata = {6'd0, out_pixel.argb, out_pixel.row, out_pixel.column};

endmodule
